### rtl/core/bctc_pkg.sv
// Block cache tag controller: shared constants, result kinds, queue entry type.
// No dependencies; every other file in rtl/core refers to this package by scope.
package bctc_pkg;

	localparam int SLOTS      = 256;
	localparam int DEVICES    = 8;

	localparam int FUNC_W     = 2;
	localparam int DEV_W      = 4;
	localparam int BLK_W      = 32;
	localparam int KIND_W     = 3;
	localparam int SLOT_OUT_W = 8;

	localparam int SLOT_W     = $clog2(SLOTS);
	localparam int ISS_W      = SLOT_W + 1;
	localparam int TAG_W      = DEV_W + BLK_W;
	localparam int DEV_CMP_W  = DEV_W + 1;

	localparam int QDEPTH     = 2;
	localparam int QPTR_W     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W     = $clog2(QDEPTH + 1);

	localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd1;

	typedef enum logic [KIND_W-1:0] {
		KIND_WB    = 3'd0,
		KIND_LOAD  = 3'd1,
		KIND_READ  = 3'd2,
		KIND_WRITE = 3'd3,
		KIND_ERR   = 3'd4
	} kind_t;

	// classified request handed from front to back
	typedef struct packed {
		logic             err;
		logic             wr;
		logic [DEV_W-1:0] device;
		logic [BLK_W-1:0] block;
	} req_t;

	// low bits of a slot index, zero-extended when the index is narrower
	function automatic logic [SLOT_OUT_W-1:0] slot_field(input logic [SLOT_W-1:0] idx);
		logic [SLOT_W+SLOT_OUT_W-1:0] ext;
		ext = {{SLOT_OUT_W{1'b0}}, idx};
		return ext[SLOT_OUT_W-1:0];
	endfunction

endpackage

### rtl/core/bctc_if.sv
// Valid/ready channel interfaces for requests and results.
// Depends on bctc_pkg for field widths.
interface bctc_req_if;
	logic                          valid;
	logic                          ready;
	logic [bctc_pkg::FUNC_W-1:0]   func;
	logic [bctc_pkg::DEV_W-1:0]    device;
	logic [bctc_pkg::BLK_W-1:0]    block_number;

	modport source (output valid, func, device, block_number, input ready);
	modport sink   (input valid, func, device, block_number, output ready);
endinterface

interface bctc_rsp_if;
	logic                            valid;
	logic                            ready;
	logic [bctc_pkg::KIND_W-1:0]     kind;
	logic [bctc_pkg::SLOT_OUT_W-1:0] slot;
	logic [bctc_pkg::DEV_W-1:0]      out_device;
	logic [bctc_pkg::BLK_W-1:0]      out_block;
	logic                            was_hit;
	logic                            last;

	modport source (output valid, kind, slot, out_device, out_block, was_hit, last, input ready);
	modport sink   (input valid, kind, slot, out_device, out_block, was_hit, last, output ready);
endinterface

### rtl/core/block_cache_tag_controller.sv
// Top level of the block cache tag controller: request queue front end and scan back end.
// Depends on bctc_pkg, bctc_if, bctc_front and bctc_back.
//
//   channel  dir  beat contents
//   req      in   func, device, block_number
//   rsp      out  kind, slot, out_device, out_block, was_hit, last
//
// A miss scans every slot, reading the tag store one entry a cycle over its single read
// port, then issues up to three result beats: writeback if needed, load, reply. A hit in
// slot k ends the scan there; an error request skips the scan and goes straight to the
// reply.
// Reset clears valid and dirty bits at once; tags need no clearing.
// A two-entry queue keeps taking requests while the scan runs or rsp stalls.
module block_cache_tag_controller (
	input  logic       clk,
	input  logic       arst_n,
	bctc_req_if.sink   req,
	bctc_rsp_if.source rsp
);

	logic           q_valid;
	logic           q_ready;
	bctc_pkg::req_t q_data;

	bctc_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.q_valid (q_valid),
		.q_ready (q_ready),
		.q_data  (q_data)
	);

	bctc_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_ready (q_ready),
		.q_data  (q_data),
		.rsp     (rsp)
	);

endmodule

### rtl/core/bctc_front.sv
// Front end: takes request beats, flags bad operations and devices, and queues them.
// Depends on bctc_pkg and bctc_req_if.
module bctc_front (
	input  logic              clk,
	input  logic              arst_n,
	bctc_req_if.sink          req,
	output logic              q_valid,
	input  logic              q_ready,
	output bctc_pkg::req_t    q_data
);

	bctc_pkg::req_t                   q_mem [bctc_pkg::QDEPTH];
	logic [bctc_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [bctc_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [bctc_pkg::QCNT_W-1:0]      cnt_q;
	logic                             push;
	logic                             pop;
	bctc_pkg::req_t                   cls;

	always_comb begin
		cls.err    = !(req.func inside {bctc_pkg::FUNC_READ, bctc_pkg::FUNC_WRITE}) ||
		             (bctc_pkg::DEV_CMP_W'(req.device) >= bctc_pkg::DEV_CMP_W'(bctc_pkg::DEVICES));
		cls.wr     = (req.func == bctc_pkg::FUNC_WRITE);
		cls.device = req.device;
		cls.block  = req.block_number;
	end

	assign req.ready = (cnt_q != bctc_pkg::QCNT_W'(bctc_pkg::QDEPTH));
	assign push      = req.valid && req.ready;
	assign q_valid   = (cnt_q != '0);
	assign pop       = q_valid && q_ready;
	assign q_data    = q_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == bctc_pkg::QPTR_W'(bctc_pkg::QDEPTH - 1)) ? '0 :
				            wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == bctc_pkg::QPTR_W'(bctc_pkg::QDEPTH - 1)) ? '0 :
				            rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

### rtl/core/bctc_back.sv
// Back end: tag store, linear lookup/victim scan, command and reply issue.
// Depends on bctc_pkg and bctc_rsp_if; fed by bctc_front's queue.
module bctc_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	output logic              q_ready,
	input  bctc_pkg::req_t    q_data,
	bctc_rsp_if.source        rsp
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_SCAN  = 5'b00010,
		ST_WB    = 5'b00100,
		ST_LOAD  = 5'b01000,
		ST_REPLY = 5'b10000
	} state_t;

	state_t                           state_q;
	bctc_pkg::req_t                   req_q;

	logic [bctc_pkg::TAG_W-1:0]       tag_mem [bctc_pkg::SLOTS];
	logic [bctc_pkg::SLOTS-1:0]       valid_q;
	logic [bctc_pkg::SLOTS-1:0]       dirty_q;

	logic [bctc_pkg::ISS_W-1:0]       iss_q;
	logic                             cmp_vld_s1;
	logic [bctc_pkg::SLOT_W-1:0]      idx_s1;
	logic [bctc_pkg::TAG_W-1:0]       rd_data_s1;

	logic                             found_q;
	logic [bctc_pkg::SLOT_W-1:0]      victim_q;
	logic [bctc_pkg::SLOT_W-1:0]      slot_q;
	logic                             hit_q;
	logic [bctc_pkg::TAG_W-1:0]       wb_tag_q;

	logic                             out_vld_q;
	bctc_pkg::kind_t                  out_kind_q;
	logic [bctc_pkg::SLOT_OUT_W-1:0]  out_slot_q;
	logic [bctc_pkg::DEV_W-1:0]       out_dev_q;
	logic [bctc_pkg::BLK_W-1:0]       out_blk_q;
	logic                             out_hit_q;
	logic                             out_last_q;

	logic                             rd_en;
	logic                             hit_now;
	logic                             clean_now;
	logic                             scan_end;
	logic                             emit;
	logic                             out_ld;
	logic                             mem_we;
	bctc_pkg::kind_t                  nx_kind;
	logic [bctc_pkg::SLOT_OUT_W-1:0]  nx_slot;
	logic [bctc_pkg::DEV_W-1:0]       nx_dev;
	logic [bctc_pkg::BLK_W-1:0]       nx_blk;
	logic                             nx_hit;
	logic                             nx_last;

	localparam logic [bctc_pkg::SLOT_W-1:0] LAST_IDX = bctc_pkg::SLOT_W'(bctc_pkg::SLOTS - 1);

	assign q_ready = (state_q == ST_IDLE);

	// tag read is registered; the compare uses it in the next cycle
	assign rd_en     = (state_q == ST_SCAN) && (iss_q < bctc_pkg::ISS_W'(bctc_pkg::SLOTS)) &&
	                   !hit_now;
	assign hit_now   = cmp_vld_s1 && valid_q[idx_s1] &&
	                   (rd_data_s1 == {req_q.device, req_q.block});
	assign clean_now = cmp_vld_s1 && (!valid_q[idx_s1] || !dirty_q[idx_s1]);
	assign scan_end  = cmp_vld_s1 && !hit_now && (idx_s1 == LAST_IDX);

	assign emit   = (state_q == ST_WB) || (state_q == ST_LOAD) || (state_q == ST_REPLY);
	assign out_ld = emit && (!out_vld_q || rsp.ready);
	assign mem_we = (state_q == ST_LOAD) && out_ld;

	always_comb begin
		nx_kind = bctc_pkg::KIND_ERR;
		nx_slot = bctc_pkg::slot_field(slot_q);
		nx_dev  = req_q.device;
		nx_blk  = req_q.block;
		nx_hit  = 1'b0;
		nx_last = 1'b0;
		case (state_q)
			ST_WB: begin
				nx_kind = bctc_pkg::KIND_WB;
				nx_dev  = wb_tag_q[bctc_pkg::TAG_W-1:bctc_pkg::BLK_W];
				nx_blk  = wb_tag_q[bctc_pkg::BLK_W-1:0];
			end
			ST_LOAD: begin
				nx_kind = bctc_pkg::KIND_LOAD;
			end
			ST_REPLY: begin
				nx_last = 1'b1;
				if (req_q.err) begin
					nx_kind = bctc_pkg::KIND_ERR;
					nx_slot = '0;
					nx_dev  = '0;
					nx_blk  = '0;
				end else begin
					nx_kind = req_q.wr ? bctc_pkg::KIND_WRITE : bctc_pkg::KIND_READ;
					nx_hit  = hit_q;
				end
			end
			default: begin
				nx_kind = bctc_pkg::KIND_ERR;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= tag_mem[iss_q[bctc_pkg::SLOT_W-1:0]];
		end
		if (mem_we) begin
			tag_mem[slot_q] <= {req_q.device, req_q.block};
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= iss_q[bctc_pkg::SLOT_W-1:0];
		if (q_valid && q_ready) begin
			req_q <= q_data;
		end
		if (state_q == ST_SCAN && scan_end && !found_q && !clean_now) begin
			wb_tag_q <= rd_data_s1;
		end
		if (out_ld) begin
			out_kind_q <= nx_kind;
			out_slot_q <= nx_slot;
			out_dev_q  <= nx_dev;
			out_blk_q  <= nx_blk;
			out_hit_q  <= nx_hit;
			out_last_q <= nx_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			valid_q    <= '0;
			dirty_q    <= '0;
			iss_q      <= '0;
			cmp_vld_s1 <= 1'b0;
			found_q    <= 1'b0;
			victim_q   <= '0;
			slot_q     <= '0;
			hit_q      <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			cmp_vld_s1 <= rd_en;
			if (out_ld) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						iss_q   <= '0;
						found_q <= 1'b0;
						hit_q   <= 1'b0;
						state_q <= q_data.err ? ST_REPLY : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (rd_en) begin
						iss_q <= iss_q + 1'b1;
					end
					if (hit_now) begin
						slot_q  <= idx_s1;
						hit_q   <= 1'b1;
						state_q <= ST_REPLY;
					end else if (scan_end) begin
						if (found_q) begin
							slot_q  <= victim_q;
							state_q <= ST_LOAD;
						end else if (clean_now) begin
							slot_q  <= idx_s1;
							state_q <= ST_LOAD;
						end else begin
							// every slot valid and dirty: evict the last one
							slot_q  <= LAST_IDX;
							state_q <= ST_WB;
						end
					end else if (clean_now && !found_q) begin
						found_q  <= 1'b1;
						victim_q <= idx_s1;
					end
				end
				ST_WB: begin
					if (out_ld) begin
						dirty_q[slot_q] <= 1'b0;
						state_q         <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					if (out_ld) begin
						valid_q[slot_q] <= 1'b1;
						dirty_q[slot_q] <= 1'b0;
						state_q         <= ST_REPLY;
					end
				end
				ST_REPLY: begin
					if (out_ld) begin
						if (!req_q.err && req_q.wr) begin
							dirty_q[slot_q] <= 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid      = out_vld_q;
	assign rsp.kind       = out_kind_q;
	assign rsp.slot       = out_slot_q;
	assign rsp.out_device = out_dev_q;
	assign rsp.out_block  = out_blk_q;
	assign rsp.was_hit    = out_hit_q;
	assign rsp.last       = out_last_q;

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("back state not one-hot");

	a_cmp_from_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmp_vld_s1 |-> $past(state_q == ST_SCAN))
		else $error("tag compare outside scan");

	a_wb_dirty_victim: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WB) |-> (valid_q[slot_q] && dirty_q[slot_q]))
		else $error("writeback of clean or invalid slot");

	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |=> (valid_q[$past(slot_q)] && !dirty_q[$past(slot_q)]))
		else $error("loaded slot not valid and clean");

	a_pop_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(q_valid && q_ready) |-> (!emit && !cmp_vld_s1))
		else $error("request taken while busy");

endmodule

### sim/tb_block_cache_tag_controller.sv
// Self-checking bench for block_cache_tag_controller: bursty request driver, stalling
// result sink, tag store predictor and in-order result checker.
// Depends on bctc_pkg, bctc_if and the controller RTL.
module tb_block_cache_tag_controller;
	timeunit 1ns;
	timeprecision 1ps;

	import bctc_pkg::*;

	localparam int CLK_HALF   = 10;
	localparam int LIMIT      = 1_000_000;
	localparam int TAIL       = 300;
	localparam int HOLD_AT    = 150;
	localparam int HOLD_LEN   = 2000;
	localparam int MAX_PRINTS = 40;
	localparam int FILL_ITEMS = 320;
	localparam int MIX_ITEMS  = 100;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [DEV_W-1:0]  dev;
		logic [BLK_W-1:0]  blk;
	} request_t;

	typedef struct packed {
		logic [KIND_W-1:0]     kind;
		logic [SLOT_OUT_W-1:0] slot;
		logic [DEV_W-1:0]      dev;
		logic [BLK_W-1:0]      blk;
		logic                  hit;
		logic                  last;
	} result_t;

	typedef enum int {RX_FREE, RX_COIN, RX_SPARSE} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n;

	bctc_req_if req_ch();
	bctc_rsp_if rsp_ch();

	block_cache_tag_controller DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// predicted tag store
	bit               line_valid [SLOTS];
	bit               line_dirty [SLOTS];
	logic [DEV_W-1:0] line_dev   [SLOTS];
	logic [BLK_W-1:0] line_blk   [SLOTS];

	request_t req_backlog[$];
	request_t address_pool[$];
	result_t  expected_results[$];

	int          fail_count;
	int          req_beats;
	int          rsp_beats;
	int unsigned cycle_count;

	task automatic report_mismatch(input string msg);
		fail_count++;
		if (fail_count <= MAX_PRINTS)
			$display("[%0t] result beat %0d: %s", $realtime, rsp_beats, msg);
	endtask

	function automatic void push_result(input kind_t k, input int s,
			input logic [DEV_W-1:0] d, input logic [BLK_W-1:0] b,
			input logic h, input logic l);
		result_t r;
		r.kind = k;
		r.slot = SLOT_OUT_W'(s);
		r.dev  = d;
		r.blk  = b;
		r.hit  = h;
		r.last = l;
		expected_results.push_back(r);
	endfunction

	// lookup, victim choice and tag update for one accepted request
	function automatic void predict_lookup(input request_t rq);
		int hit_slot;
		int victim;
		kind_t reply;
		hit_slot = -1;
		victim = -1;
		if ((rq.func != FUNC_READ && rq.func != FUNC_WRITE) || rq.dev >= DEVICES) begin
			push_result(KIND_ERR, 0, '0, '0, 1'b0, 1'b1);
			return;
		end
		reply = (rq.func == FUNC_WRITE) ? KIND_WRITE : KIND_READ;
		for (int i = 0; i < SLOTS; i++)
			if (hit_slot < 0 && line_valid[i] && line_dev[i] == rq.dev && line_blk[i] == rq.blk)
				hit_slot = i;
		if (hit_slot >= 0) begin
			if (rq.func == FUNC_WRITE)
				line_dirty[hit_slot] = 1'b1;
			push_result(reply, hit_slot, rq.dev, rq.blk, 1'b1, 1'b1);
			return;
		end
		for (int i = 0; i < SLOTS; i++)
			if (victim < 0 && (!line_valid[i] || !line_dirty[i]))
				victim = i;
		if (victim < 0)
			victim = SLOTS - 1;
		if (line_valid[victim] && line_dirty[victim])
			push_result(KIND_WB, victim, line_dev[victim], line_blk[victim], 1'b0, 1'b0);
		push_result(KIND_LOAD, victim, rq.dev, rq.blk, 1'b0, 1'b0);
		line_valid[victim] = 1'b1;
		line_dirty[victim] = (rq.func == FUNC_WRITE);
		line_dev[victim]   = rq.dev;
		line_blk[victim]   = rq.blk;
		push_result(reply, victim, rq.dev, rq.blk, 1'b0, 1'b1);
	endfunction

	task automatic check_field(input string name, input logic [BLK_W-1:0] want,
			input logic [BLK_W-1:0] got);
		if (got !== want)
			report_mismatch($sformatf("%s want %0h got %0h", name, want, got));
	endtask

	// ---- request side: bursts with random gaps ----
	int burst_left;
	int gap_left;
	int beats_seen;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 9);
		if (r < 3)
			return 0;
		if (r < 8)
			return $urandom_range(1, 4);
		return $urandom_range(5, 30);
	endfunction

	always @(negedge clk) begin
		if (arst_n) begin
			if (req_beats != beats_seen) begin
				beats_seen = req_beats;
				if (burst_left > 0)
					burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 12);
					gap_left = pick_gap();
				end
			end
			if (gap_left > 0) begin
				gap_left--;
				req_ch.valid <= 1'b0;
			end else if (req_backlog.size() != 0) begin
				req_ch.valid        <= 1'b1;
				req_ch.func         <= req_backlog[0].func;
				req_ch.device       <= req_backlog[0].dev;
				req_ch.block_number <= req_backlog[0].blk;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && req_ch.valid && req_ch.ready) begin
			predict_lookup('{req_ch.func, req_ch.device, req_ch.block_number});
			void'(req_backlog.pop_front());
			req_beats++;
		end
	end

	// ---- result side: stall pattern plus one long hold-off ----
	rx_mode_t rx_mode;
	int       mode_left;
	int       hold_left;
	bit       hold_done;

	always @(negedge clk) begin
		if (arst_n) begin
			if (!hold_done && rsp_beats >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_LEN;
			end
			if (mode_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 2));
				mode_left = $urandom_range(20, 80);
			end else begin
				mode_left--;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				case (rx_mode)
					RX_FREE:   rsp_ch.ready <= 1'b1;
					RX_COIN:   rsp_ch.ready <= 1'($urandom_range(0, 1));
					default:   rsp_ch.ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("unexpected beat kind %0d slot %0d",
					rsp_ch.kind, rsp_ch.slot));
			end else begin
				want = expected_results.pop_front();
				check_field("kind", BLK_W'(want.kind), BLK_W'(rsp_ch.kind));
				check_field("slot", BLK_W'(want.slot), BLK_W'(rsp_ch.slot));
				check_field("out_device", BLK_W'(want.dev), BLK_W'(rsp_ch.out_device));
				check_field("out_block", want.blk, rsp_ch.out_block);
				check_field("was_hit", BLK_W'(want.hit), BLK_W'(rsp_ch.was_hit));
				check_field("last", BLK_W'(want.last), BLK_W'(rsp_ch.last));
			end
			rsp_beats++;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT) begin
			$display("[%0t] timeout, %0d results outstanding", $realtime,
				expected_results.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	// ---- stimulus ----
	task automatic add_request(input logic [FUNC_W-1:0] f, input logic [DEV_W-1:0] d,
			input logic [BLK_W-1:0] b);
		req_backlog.push_back('{f, d, b});
		if ((f == FUNC_READ || f == FUNC_WRITE) && d < DEVICES)
			address_pool.push_back('{f, d, b});
	endtask

	task automatic add_noise();
		if ($urandom_range(0, 1))
			add_request(FUNC_W'($urandom_range(2, 3)), DEV_W'($urandom_range(0, 15)),
				$urandom());
		else
			add_request(FUNC_W'($urandom_range(0, 1)), DEV_W'($urandom_range(DEVICES, 15)),
				$urandom());
	endtask

	task automatic add_reuse(input int write_pct, input int dev_swap_pct);
		request_t rq;
		rq = address_pool[$urandom_range(0, address_pool.size() - 1)];
		// same block on a randomly chosen device; another device should miss
		if ($urandom_range(0, 99) < dev_swap_pct)
			rq.dev = DEV_W'($urandom_range(0, DEVICES - 1));
		add_request(($urandom_range(0, 99) < write_pct) ? FUNC_WRITE : FUNC_READ, rq.dev, rq.blk);
	endtask

	task automatic wait_drained();
		while (req_backlog.size() != 0 || expected_results.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		int r;
		arst_n              = 1'b0;
		req_ch.valid        = 1'b0;
		req_ch.func         = FUNC_READ;
		req_ch.device       = '0;
		req_ch.block_number = '0;
		rsp_ch.ready        = 1'b0;
		burst_left          = $urandom_range(1, 12);
		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// directed: hits, misses, tag field extremes, both error cases
		add_request(FUNC_READ,  4'd0,  32'h0000_0000);
		add_request(FUNC_READ,  4'd0,  32'h0000_0000);
		add_request(FUNC_WRITE, 4'd7,  32'hFFFF_FFFF);
		add_request(FUNC_WRITE, 4'd7,  32'hFFFF_FFFF);
		add_request(2'd2,       4'd0,  32'h0000_0000);
		add_request(2'd3,       4'd15, 32'hFFFF_FFFF);
		add_request(FUNC_READ,  4'd8,  32'h0000_0005);
		add_request(FUNC_WRITE, 4'd15, 32'h0000_0000);
		add_request(FUNC_READ,  4'd0,  32'hFFFF_FFFF);
		add_request(FUNC_READ,  4'd7,  32'h0000_0000);
		add_request(FUNC_WRITE, 4'd0,  32'h0000_0000);
		add_request(FUNC_READ,  4'd1,  32'hA5A5_A5A5);
		add_request(FUNC_WRITE, 4'd6,  32'h5A5A_5A5A);
		add_request(FUNC_READ,  4'd7,  32'hFFFF_FFFF);
		add_request(FUNC_WRITE, 4'd3,  32'h8000_0000);
		add_request(FUNC_READ,  4'd3,  32'h0000_0001);
		add_request(FUNC_READ,  4'd1,  32'hA5A5_A5A5);
		add_request(FUNC_WRITE, 4'd2,  32'h0000_0001);

		// fill: mostly write misses, to leave most slots dirty
		for (int n = 0; n < FILL_ITEMS; n++) begin
			r = $urandom_range(0, 99);
			if (r < 4)
				add_noise();
			else if (r < 12)
				add_reuse(50, 10);
			else
				add_request(($urandom_range(0, 99) < 94) ? FUNC_WRITE : FUNC_READ,
					DEV_W'($urandom_range(0, DEVICES - 1)), $urandom());
		end

		// sender holds back until the block has answered everything
		wait_drained();

		// mixed traffic on a full, dirty store: hits, writebacks, errors
		for (int n = 0; n < MIX_ITEMS; n++) begin
			r = $urandom_range(0, 99);
			if (r < 15)
				add_noise();
			else if (r < 60)
				add_reuse(50, 20);
			else
				add_request(FUNC_W'($urandom_range(0, 1)),
					DEV_W'($urandom_range(0, DEVICES - 1)), $urandom());
		end

		wait_drained();
		repeat (TAIL) @(posedge clk);
		if (expected_results.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

### sim.f
rtl/core/bctc_pkg.sv
rtl/core/bctc_if.sv
rtl/core/bctc_front.sv
rtl/core/bctc_back.sv
rtl/core/block_cache_tag_controller.sv
sim/tb_block_cache_tag_controller.sv
